// ===== hdl/spectrum_band_peak_binner_defines.svh =====
// assertion helpers for the band peak binner
`ifndef SPECTRUM_BAND_PEAK_BINNER_DEFINES_SVH
`define SPECTRUM_BAND_PEAK_BINNER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SBPB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBPB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sbpb_pkg.sv =====
package sbpb_pkg;

    localparam int MAX_BANDS_DEFAULT = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam int FREQ_W   = 16;
    localparam int LEVEL_W  = 16;
    localparam int NBANDS_W = 7;
    localparam int BAND_W   = 6;
    localparam int PROD_W   = FREQ_W + NBANDS_W;

    localparam logic [LEVEL_W-1:0] AMP_ONE = 16'd32768;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FREQ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FREQ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BANDS_IN_USE = 2'd2;

    // one classified bin handed from front to back
    typedef struct packed {
        logic [BAND_W-1:0]   band;
        logic [LEVEL_W-1:0]  level;
        logic                clip;
        logic                hit;
        logic                last;
        logic [NBANDS_W-1:0] nbands;
    } bin_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_UPDATE,
        B_RD_ISSUE,
        B_RD_DATA
    } back_state_t;

endpackage

// ===== hdl/sbpb_ram.sv =====
module sbpb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sbpb_queue.sv =====
module sbpb_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sbpb_pkg::bin_entry_t push_entry,
    input  logic                 pop,
    output sbpb_pkg::bin_entry_t head,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (sbpb_pkg::QUEUE_DEPTH > 1) ? $clog2(sbpb_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sbpb_pkg::QUEUE_DEPTH + 1);

    sbpb_pkg::bin_entry_t slot_reg [sbpb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(sbpb_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full  = (count_reg == CNT_W'(sbpb_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/sbpb_front.sv =====
module sbpb_front #(
    parameter int MAX_BANDS = sbpb_pkg::MAX_BANDS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sbpb_pkg::FREQ_W-1:0]   frequency,
    input  logic [sbpb_pkg::LEVEL_W-1:0]  amplitude,
    input  logic                          clip_flag,
    input  logic                          end_of_spectrum,
    input  logic [sbpb_pkg::FREQ_W-1:0]   low_freq,
    input  logic [sbpb_pkg::FREQ_W-1:0]   high_freq,
    input  logic [sbpb_pkg::NBANDS_W-1:0] bands_in_use,
    input  logic                          q_full,
    output logic                          q_push,
    output sbpb_pkg::bin_entry_t          q_entry
);

    localparam int FW = sbpb_pkg::FREQ_W;
    localparam int LW = sbpb_pkg::LEVEL_W;
    localparam int NW = sbpb_pkg::NBANDS_W;
    localparam int PW = sbpb_pkg::PROD_W;
    localparam int BW = sbpb_pkg::BAND_W;

    sbpb_pkg::front_state_t state_reg, state_next;

    logic [FW-1:0] diff_reg, diff_next;
    logic [FW-1:0] span_reg, span_next;
    logic [LW-1:0] amp_reg, amp_next;
    logic          clip_reg, clip_next;
    logic          last_reg, last_next;
    logic          hit_reg, hit_next;
    logic [NW-1:0] n_reg, n_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [BW-1:0] quo_reg, quo_next;
    logic          step_reg, step_next;

    logic          accept;
    logic [NW-1:0] n_eff;
    logic [PW-1:0] div_rem;
    logic [BW-1:0] div_quo;
    logic [PW-1:0] trial;
    logic [2:0]    sh;

    assign accept = s_tvalid && s_tready;

    // out-of-range band counts fold to one or to the built count
    always_comb begin
        priority if (bands_in_use == '0) begin
            n_eff = NW'(1);
        end else if (bands_in_use > NW'(MAX_BANDS)) begin
            n_eff = NW'(MAX_BANDS);
        end else begin
            n_eff = bands_in_use;
        end
    end

    // three restoring quotient bits per cycle, high half first
    always_comb begin
        div_rem = rem_reg;
        div_quo = quo_reg;
        trial   = '0;
        sh      = '0;
        for (int b = 0; b < 3; b++) begin
            sh    = step_reg ? (3'd2 - 3'(b)) : (3'd5 - 3'(b));
            trial = PW'(span_reg) << sh;
            if (div_rem >= trial) begin
                div_rem     = div_rem - trial;
                div_quo[sh] = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbpb_pkg::F_IDLE: if (accept) state_next = sbpb_pkg::F_MUL;
            sbpb_pkg::F_MUL:  state_next = sbpb_pkg::F_DIV;
            sbpb_pkg::F_DIV:  if (step_reg) state_next = sbpb_pkg::F_PUSH;
            sbpb_pkg::F_PUSH: if (!q_full) state_next = sbpb_pkg::F_IDLE;
            default:          state_next = sbpb_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        diff_next = diff_reg;
        span_next = span_reg;
        amp_next  = amp_reg;
        clip_next = clip_reg;
        last_next = last_reg;
        hit_next  = hit_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        s_tready  = 1'b0;
        q_push    = 1'b0;
        unique case (state_reg)
            sbpb_pkg::F_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    diff_next = frequency - low_freq;
                    span_next = high_freq - low_freq;
                    amp_next  = (amplitude > sbpb_pkg::AMP_ONE) ? sbpb_pkg::AMP_ONE : amplitude;
                    clip_next = clip_flag;
                    last_next = end_of_spectrum;
                    hit_next  = (high_freq > low_freq) && (frequency >= low_freq)
                                && (frequency < high_freq);
                    n_next    = n_eff;
                end
            end
            sbpb_pkg::F_MUL: begin
                rem_next  = PW'(diff_reg) * PW'(n_reg);
                quo_next  = '0;
                step_next = 1'b0;
            end
            sbpb_pkg::F_DIV: begin
                rem_next  = div_rem;
                quo_next  = div_quo;
                step_next = !step_reg;
            end
            sbpb_pkg::F_PUSH: begin
                q_push = !q_full;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign q_entry.band   = quo_reg;
    assign q_entry.level  = amp_reg;
    assign q_entry.clip   = clip_reg;
    assign q_entry.hit    = hit_reg;
    assign q_entry.last   = last_reg;
    assign q_entry.nbands = n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbpb_pkg::F_IDLE;
            step_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        span_reg <= span_next;
        amp_reg  <= amp_next;
        clip_reg <= clip_next;
        last_reg <= last_next;
        hit_reg  <= hit_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

endmodule

// ===== hdl/sbpb_back.sv =====
module sbpb_back #(
    parameter int MAX_BANDS = sbpb_pkg::MAX_BANDS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  sbpb_pkg::bin_entry_t         q_head,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sbpb_pkg::BAND_W-1:0]  band_index,
    output logic [sbpb_pkg::LEVEL_W-1:0] peak_level,
    output logic                         band_clipped,
    output logic                         final_band
);

    localparam int IW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int LW = sbpb_pkg::LEVEL_W;
    localparam int NW = sbpb_pkg::NBANDS_W;
    localparam int BW = sbpb_pkg::BAND_W;
    localparam int RW = LW + 1;

    sbpb_pkg::back_state_t state_reg, state_next;

    sbpb_pkg::bin_entry_t entry_reg, entry_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [MAX_BANDS-1:0] valid_reg, valid_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [BW-1:0] band_reg, band_next;
    logic [LW-1:0] peak_reg, peak_next;
    logic          clipped_reg, clipped_next;
    logic          final_reg, final_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    logic [IW-1:0] upd_idx;
    logic [LW-1:0] old_peak;
    logic          old_clip;
    logic [LW-1:0] rd_peak;
    logic          rd_clip;
    logic          out_free;
    logic          k_last;

    sbpb_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_BANDS)
    ) u_band_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign upd_idx  = entry_reg.band[IW-1:0];
    assign old_peak = valid_reg[upd_idx] ? ram_rdata[LW-1:0] : '0;
    assign old_clip = valid_reg[upd_idx] && ram_rdata[LW];
    assign rd_peak  = valid_reg[k_reg] ? ram_rdata[LW-1:0] : '0;
    assign rd_clip  = valid_reg[k_reg] && ram_rdata[LW];
    assign out_free = !m_tvalid_reg || m_tready;
    assign k_last   = (NW'(k_reg) == (entry_reg.nbands - NW'(1)));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbpb_pkg::B_IDLE: begin
                if (!q_empty) begin
                    priority if (q_head.hit) begin
                        state_next = sbpb_pkg::B_UPDATE;
                    end else if (q_head.last) begin
                        state_next = sbpb_pkg::B_RD_ISSUE;
                    end
                end
            end
            sbpb_pkg::B_UPDATE: begin
                state_next = entry_reg.last ? sbpb_pkg::B_RD_ISSUE : sbpb_pkg::B_IDLE;
            end
            sbpb_pkg::B_RD_ISSUE: state_next = sbpb_pkg::B_RD_DATA;
            sbpb_pkg::B_RD_DATA: begin
                if (out_free) begin
                    state_next = k_last ? sbpb_pkg::B_IDLE : sbpb_pkg::B_RD_ISSUE;
                end
            end
            default: state_next = sbpb_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        entry_next    = entry_reg;
        k_next        = k_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        band_next     = band_reg;
        peak_next     = peak_reg;
        clipped_next  = clipped_reg;
        final_next    = final_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = upd_idx;
        ram_wdata     = {old_clip | entry_reg.clip,
                         (entry_reg.level > old_peak) ? entry_reg.level : old_peak};
        ram_re        = 1'b0;
        ram_raddr     = k_reg;
        unique case (state_reg)
            sbpb_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    entry_next = q_head;
                    ram_re     = 1'b1;
                    ram_raddr  = q_head.band[IW-1:0];
                    k_next     = '0;
                end
            end
            sbpb_pkg::B_UPDATE: begin
                ram_we              = 1'b1;
                valid_next[upd_idx] = 1'b1;
                k_next              = '0;
            end
            sbpb_pkg::B_RD_ISSUE: begin
                ram_re = 1'b1;
            end
            sbpb_pkg::B_RD_DATA: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    band_next     = BW'(k_reg);
                    peak_next     = rd_peak;
                    clipped_next  = rd_clip;
                    final_next    = k_last;
                    if (k_last) begin
                        valid_next = '0;
                    end else begin
                        k_next = k_reg + IW'(1);
                    end
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign m_tvalid     = m_tvalid_reg;
    assign band_index   = band_reg;
    assign peak_level   = peak_reg;
    assign band_clipped = clipped_reg;
    assign final_band   = final_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sbpb_pkg::B_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg   <= entry_next;
        k_reg       <= k_next;
        band_reg    <= band_next;
        peak_reg    <= peak_next;
        clipped_reg <= clipped_next;
        final_reg   <= final_next;
    end

endmodule

// ===== hdl/spectrum_band_peak_binner.sv =====
// Spectrum band peak binner. Takes the bins of one spectrum, one per s_ transaction, and
// sorts each bin with low_freq <= frequency < high_freq into band
// floor((frequency - low_freq) * N / (high_freq - low_freq)), N being bands_in_use folded
// into 1..MAX_BANDS. Each band holds the largest amplitude seen (saturated to 1.0 in Q1.15)
// and the OR of its clip flags. The bin carrying s_tlast is binned first, then bands
// 0..N-1 go out as m_ transactions in order, m_tlast on the last, and all bands clear.
// The front holds one bin at a time: capture, 16x7 multiply, a divider giving three
// quotient bits per cycle, hand-off into a 4-entry queue (waiting while it is full). The
// back drops an ignored bin as it pops it and puts a binned bin through the band memory's
// read-modify-write, so the front sets the sustained rate. Each band's readout waits on the
// registered band memory read and on m_tready. Config writes belong in idle periods only.
`include "spectrum_band_peak_binner_defines.svh"

module spectrum_band_peak_binner #(
    parameter int MAX_BANDS = sbpb_pkg::MAX_BANDS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write port
    input  logic                              cfg_we,
    input  logic [sbpb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbpb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // bin input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,  // frequency, amplitude, clip_flag, zero pad
    input  logic                              s_tlast,  // end_of_spectrum
    // band output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // band_index, peak_level, band_clipped, zero pad
    output logic                              m_tlast   // final_band
);

    localparam int FW = sbpb_pkg::FREQ_W;
    localparam int LW = sbpb_pkg::LEVEL_W;
    localparam int NW = sbpb_pkg::NBANDS_W;
    localparam int BW = sbpb_pkg::BAND_W;

    // config registers
    logic [FW-1:0] low_freq_reg, low_freq_next;
    logic [FW-1:0] high_freq_reg, high_freq_next;
    logic [NW-1:0] bands_reg, bands_next;

    // front to queue to back
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    sbpb_pkg::bin_entry_t q_entry;
    sbpb_pkg::bin_entry_t q_head;

    // output fields
    logic [BW-1:0] band_index;
    logic [LW-1:0] peak_level;
    logic          band_clipped;

    // unknown register index leaves everything as is
    always_comb begin
        low_freq_next  = low_freq_reg;
        high_freq_next = high_freq_reg;
        bands_next     = bands_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                sbpb_pkg::REG_LOW_FREQ:     low_freq_next  = cfg_wdata[FW-1:0];
                sbpb_pkg::REG_HIGH_FREQ:    high_freq_next = cfg_wdata[FW-1:0];
                sbpb_pkg::REG_BANDS_IN_USE: bands_next     = cfg_wdata[NW-1:0];
                default:                    bands_next     = bands_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_freq_reg  <= '0;
            high_freq_reg <= FW'(1000);
            bands_reg     <= NW'(16);
        end else begin
            low_freq_reg  <= low_freq_next;
            high_freq_reg <= high_freq_next;
            bands_reg     <= bands_next;
        end
    end

    // classify: range check, band index by multiply and divide
    sbpb_front #(
        .MAX_BANDS (MAX_BANDS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .frequency       (s_tdata[15:0]),
        .amplitude       (s_tdata[31:16]),
        .clip_flag       (s_tdata[32]),
        .end_of_spectrum (s_tlast),
        .low_freq        (low_freq_reg),
        .high_freq       (high_freq_reg),
        .bands_in_use    (bands_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_entry)
    );

    // decouples classification from the band memory updates and readout
    sbpb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // band memory update, readout and clear, output register
    sbpb_back #(
        .MAX_BANDS (MAX_BANDS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .band_index   (band_index),
        .peak_level   (peak_level),
        .band_clipped (band_clipped),
        .final_band   (m_tlast)
    );

    assign m_tdata = {1'b0, band_clipped, peak_level, band_index};

    // queue is never pushed when full nor popped when empty
    `SBPB_ASSERT_NOW(a_no_overflow, aclk, aresetn, q_push, !q_full, "queue push while full")
    `SBPB_ASSERT_NOW(a_no_underflow, aclk, aresetn, q_pop, !q_empty, "queue pop while empty")
    // front holds one bin at a time
    `SBPB_ASSERT_NEXT(a_one_bin, aclk, aresetn, s_tvalid && s_tready, !s_tready, "bins back to back")

endmodule
